// File: hdl/sbfc_pkg.sv
package sbfc_pkg;

    // Function codes carried in the func field of an input word
    localparam logic [1:0] FN_RX_BYTE  = 2'd0;
    localparam logic [1:0] FN_TX_START = 2'd1;
    localparam logic [1:0] FN_TX_DONE  = 2'd2;
    localparam logic [1:0] FN_TICK     = 2'd3;

    localparam int PhaseW = 4;
    localparam int TimerW = 24;

    localparam logic [TimerW-1:0] TimeoutReset = TimerW'(10000);

    // Receive phase: wait for start byte, then index of the next byte
    localparam logic [PhaseW-1:0] RX_WAIT = 4'd0;
    localparam logic [PhaseW-1:0] RX_B1   = 4'd1;
    localparam logic [PhaseW-1:0] RX_B2   = 4'd2;
    localparam logic [PhaseW-1:0] RX_B3   = 4'd3;
    localparam logic [PhaseW-1:0] RX_B4   = 4'd4;
    localparam logic [PhaseW-1:0] RX_B5   = 4'd5;
    localparam logic [PhaseW-1:0] RX_B6   = 4'd6;
    localparam logic [PhaseW-1:0] RX_B7   = 4'd7;
    localparam logic [PhaseW-1:0] RX_B8   = 4'd8;

    // Transmit phase: idle, then index of the pending byte
    localparam logic [PhaseW-1:0] TX_IDLE = 4'd0;
    localparam logic [PhaseW-1:0] TX_B1   = 4'd1;
    localparam logic [PhaseW-1:0] TX_B2   = 4'd2;
    localparam logic [PhaseW-1:0] TX_B3   = 4'd3;
    localparam logic [PhaseW-1:0] TX_B4   = 4'd4;
    localparam logic [PhaseW-1:0] TX_B5   = 4'd5;
    localparam logic [PhaseW-1:0] TX_B6   = 4'd6;
    localparam logic [PhaseW-1:0] TX_B7   = 4'd7;
    localparam logic [PhaseW-1:0] TX_B8   = 4'd8;
    localparam logic [PhaseW-1:0] TX_B9   = 4'd9;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  rx_byte;
        logic [14:0] tx_word0;
        logic [15:0] tx_word1;
        logic [15:0] tx_word2;
        logic [15:0] tx_word3;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  tx_char;
        logic        tx_valid;
        logic        tx_idle;
        logic        frame_done;
        logic [14:0] rx_word0;
        logic [15:0] rx_word1;
        logic [15:0] rx_word2;
        logic [15:0] rx_word3;
        logic        comms_lost;
    } t_out_word;

    typedef struct packed {
        logic [14:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } t_store;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        t_store            store;
        logic              done;
    } t_rx_upd;

endpackage

// File: hdl/seven_bit_frame_codec.sv
// Path: an accepted word lands in the input register; its result word is then loaded
// into the result register and shown from there, and an output stall holds the word
// in the input register until the result register can load.
// Throughput: one word per cycle; the state update runs in a single pass between
// the input register and the result register, stalled only by i_out_ready.
// Reset (synchronous, i_rst_n low): both registers empty, phases idle, store and
// silence count zero, comms lost clear, timeout register back to 10000 ticks.
module seven_bit_frame_codec
    import sbfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TimerW-1:0] i_cfg_data
);

    // Pipeline registers
    logic      r_in_valid;
    t_in_word  r_in_data;
    logic      r_out_valid;
    t_out_word r_out_data;

    // Architectural state
    logic [TimerW-1:0] r_timeout;
    logic [PhaseW-1:0] r_rx_phase;
    logic [PhaseW-1:0] r_tx_phase;
    t_store            r_store;
    logic [TimerW-1:0] r_silence;
    logic              r_lost;

    logic [PhaseW-1:0] n_rx_phase;
    logic [PhaseW-1:0] n_tx_phase;
    t_store            n_store;
    logic [TimerW-1:0] n_silence;
    logic              n_lost;
    logic              n_done;
    t_out_word         n_out_data;

    logic              w_out_load;
    logic              w_adv;
    t_rx_upd           w_rx_upd;
    logic [7:0]        w_char;
    logic [TimerW:0]   w_tick_next;

    // The result register frees when it is empty or its word is taken now.
    // The input register advances whenever the result register can load,
    // so a new word enters every cycle the output side keeps up.
    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_load;
    assign o_in_ready = !r_in_valid || w_out_load;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= (i_in_valid && o_in_ready) || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TimeoutReset;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Unpack a received byte into the shared store
    sbfc_rx_unpack u_rx (
        .i_phase (r_rx_phase),
        .i_byte  (r_in_data.rx_byte),
        .i_store (r_store),
        .o_upd   (w_rx_upd)
    );

    assign w_tick_next = {1'b0, r_silence} + {{TimerW{1'b0}}, 1'b1};

    // Next state for the word sitting in the input register
    always_comb begin
        n_rx_phase = r_rx_phase;
        n_tx_phase = r_tx_phase;
        n_store    = r_store;
        n_silence  = r_silence;
        n_lost     = r_lost;
        n_done     = 1'b0;
        case (r_in_data.func)
            FN_RX_BYTE: begin
                n_rx_phase = w_rx_upd.phase;
                n_store    = w_rx_upd.store;
                n_done     = w_rx_upd.done;
                // a completed frame clears comms lost and restarts the timeout
                if (w_rx_upd.done) begin
                    n_lost    = 1'b0;
                    n_silence = '0;
                end
            end
            FN_TX_START: begin
                // reload the store and restart with the start byte
                n_store.w0 = r_in_data.tx_word0;
                n_store.w1 = r_in_data.tx_word1;
                n_store.w2 = r_in_data.tx_word2;
                n_store.w3 = r_in_data.tx_word3;
                n_tx_phase = TX_B1;
            end
            FN_TX_DONE: begin
                // advance to the next byte; return to idle after the last one
                if (r_tx_phase >= TX_B9) begin
                    n_tx_phase = TX_IDLE;
                end else if (r_tx_phase != TX_IDLE) begin
                    n_tx_phase = r_tx_phase + PhaseW'(1);
                end
            end
            FN_TICK: begin
                if (w_tick_next >= {1'b0, r_timeout}) begin
                    n_lost    = 1'b1;
                    n_silence = '0;
                end else begin
                    n_silence = w_tick_next[TimerW-1:0];
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Pending byte is taken from the updated phase and store
    sbfc_tx_pack u_tx (
        .i_phase (n_tx_phase),
        .i_store (n_store),
        .o_char  (w_char)
    );

    always_comb begin
        n_out_data.tx_char    = w_char;
        n_out_data.tx_valid   = (n_tx_phase != TX_IDLE);
        n_out_data.tx_idle    = (n_tx_phase == TX_IDLE);
        n_out_data.frame_done = n_done;
        n_out_data.rx_word0   = n_store.w0;
        n_out_data.rx_word1   = n_store.w1;
        n_out_data.rx_word2   = n_store.w2;
        n_out_data.rx_word3   = n_store.w3;
        n_out_data.comms_lost = n_lost;
    end

    // Commit state only when the word moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase <= RX_WAIT;
            r_tx_phase <= TX_IDLE;
            r_store    <= '0;
            r_silence  <= '0;
            r_lost     <= 1'b0;
        end else if (w_adv) begin
            r_rx_phase <= n_rx_phase;
            r_tx_phase <= n_tx_phase;
            r_store    <= n_store;
            r_silence  <= n_silence;
            r_lost     <= n_lost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A completed frame always reports comms as present
    a_done_clears_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |-> !o_out_data.comms_lost)
        else $error("frame done reported with comms lost");

    // No pending byte means a zero character
    a_idle_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.tx_valid |-> o_out_data.tx_char == 8'd0)
        else $error("character shown while transmitter idle");

    // Phase counters stay within the frame length
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_phase <= RX_B8 && r_tx_phase <= TX_B9)
        else $error("phase counter out of range");

    // State holds while the result register is stalled
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_tx_phase) && $stable(r_store))
        else $error("state changed during output stall");

    // A transmit start always presents a start character
    a_start_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_data.func == FN_TX_START |=> r_out_data.tx_char[7])
        else $error("transmit start did not present a start byte");

endmodule

// File: hdl/sbfc_rx_unpack.sv
module sbfc_rx_unpack
    import sbfc_pkg::*;
(
    input  logic [PhaseW-1:0] i_phase,
    input  logic [7:0]        i_byte,
    input  t_store            i_store,
    output t_rx_upd           o_upd
);

    logic [6:0] w_d;

    assign w_d = i_byte[6:0];

    always_comb begin
        o_upd.phase = i_phase;
        o_upd.store = i_store;
        o_upd.done  = 1'b0;
        if (i_byte[7]) begin
            // start byte restarts the frame in any phase
            o_upd.store.w0 = {w_d, 8'd0};
            o_upd.phase    = RX_B1;
        end else begin
            case (i_phase)
                RX_B1: begin
                    o_upd.store.w0 = i_store.w0 | {7'd0, w_d, 1'b0};
                    o_upd.phase    = RX_B2;
                end
                RX_B2: begin
                    o_upd.store.w0 = i_store.w0 | {14'd0, i_byte[6]};
                    o_upd.store.w1 = {i_byte[5:0], 10'd0};
                    o_upd.phase    = RX_B3;
                end
                RX_B3: begin
                    o_upd.store.w1 = i_store.w1 | {6'd0, w_d, 3'd0};
                    o_upd.phase    = RX_B4;
                end
                RX_B4: begin
                    o_upd.store.w1 = i_store.w1 | {13'd0, i_byte[6:4]};
                    o_upd.store.w2 = {i_byte[3:0], 12'd0};
                    o_upd.phase    = RX_B5;
                end
                RX_B5: begin
                    o_upd.store.w2 = i_store.w2 | {4'd0, w_d, 5'd0};
                    o_upd.phase    = RX_B6;
                end
                RX_B6: begin
                    o_upd.store.w2 = i_store.w2 | {11'd0, i_byte[6:2]};
                    o_upd.store.w3 = {i_byte[1:0], 14'd0};
                    o_upd.phase    = RX_B7;
                end
                RX_B7: begin
                    o_upd.store.w3 = i_store.w3 | {2'd0, w_d, 7'd0};
                    o_upd.phase    = RX_B8;
                end
                RX_B8: begin
                    o_upd.store.w3 = i_store.w3 | {9'd0, w_d};
                    o_upd.phase    = RX_WAIT;
                    o_upd.done     = 1'b1;
                end
                default: begin
                    // drop data bytes while waiting for a start byte
                    o_upd.phase = i_phase;
                end
            endcase
        end
    end

endmodule

// File: hdl/sbfc_tx_pack.sv
module sbfc_tx_pack
    import sbfc_pkg::*;
(
    input  logic [PhaseW-1:0] i_phase,
    input  t_store            i_store,
    output logic [7:0]        o_char
);

    always_comb begin
        case (i_phase)
            TX_B1:   o_char = {1'b1, i_store.w0[14:8]};
            TX_B2:   o_char = {1'b0, i_store.w0[7:1]};
            TX_B3:   o_char = {1'b0, i_store.w0[0], i_store.w1[15:10]};
            TX_B4:   o_char = {1'b0, i_store.w1[9:3]};
            TX_B5:   o_char = {1'b0, i_store.w1[2:0], i_store.w2[15:12]};
            TX_B6:   o_char = {1'b0, i_store.w2[11:5]};
            TX_B7:   o_char = {1'b0, i_store.w2[4:0], i_store.w3[15:14]};
            TX_B8:   o_char = {1'b0, i_store.w3[13:7]};
            TX_B9:   o_char = {1'b0, i_store.w3[6:0]};
            default: o_char = 8'd0;
        endcase
    end

endmodule

// File: tb/seven_bit_frame_codec_tb.sv
`timescale 1ns / 100ps

module seven_bit_frame_codec_tb;
    import sbfc_pkg::*;

    // Mirror of the codec: holds its own copy of the phases, the shared frame
    // store, the silence counter and the timeout register, and queues the
    // result word that every accepted input word must produce.
    class frame_codec_mirror;
        logic [TimerW-1:0] lost_limit;
        logic [PhaseW-1:0] rx_phase;
        logic [PhaseW-1:0] tx_phase;
        t_store            store;
        logic [TimerW-1:0] silence;
        logic              lost;
        t_out_word         due_words[$];
        int                errors;

        function new();
            lost_limit = TimeoutReset;
            rx_phase   = RX_WAIT;
            tx_phase   = TX_IDLE;
            store      = '0;
            silence    = '0;
            lost       = 1'b0;
            errors     = 0;
        endfunction

        // Byte on the line for the current transmit phase: seven bits of the
        // 63-bit stream, most significant first, bit 7 marks the start byte.
        function logic [7:0] char_on_line();
            int top;
            if (tx_phase == TX_IDLE || tx_phase > TX_B9)
                return 8'h00;
            top = 62 - 7 * (int'(tx_phase) - 1);
            return {tx_phase == TX_B1, store[top -: 7]};
        endfunction

        // Unpack one received byte; the first word of a field is assigned,
        // the rest is merged in, so a store loaded for sending shows through.
        function logic take_byte(logic [7:0] c);
            logic [6:0] d;
            d = c[6:0];
            if (c[7]) begin
                store.w0 = {d, 8'h00};
                rx_phase = RX_B1;
                return 1'b0;
            end
            case (rx_phase)
                RX_B1: store.w0 |= {7'd0, d, 1'b0};
                RX_B2: begin
                    store.w0[0] |= c[6];
                    store.w1 = {c[5:0], 10'd0};
                end
                RX_B3: store.w1 |= {6'd0, d, 3'd0};
                RX_B4: begin
                    store.w1[2:0] |= c[6:4];
                    store.w2 = {c[3:0], 12'd0};
                end
                RX_B5: store.w2 |= {4'd0, d, 5'd0};
                RX_B6: begin
                    store.w2[4:0] |= c[6:2];
                    store.w3 = {c[1:0], 14'd0};
                end
                RX_B7: store.w3 |= {2'd0, d, 7'd0};
                RX_B8: begin
                    store.w3[6:0] |= d;
                    lost     = 1'b0;
                    silence  = '0;
                    rx_phase = RX_WAIT;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
            rx_phase++;
            return 1'b0;
        endfunction

        function void absorb(t_in_word w);
            logic            done;
            logic [TimerW:0] next;
            t_out_word       want;
            done = 1'b0;
            case (w.func)
                FN_RX_BYTE: done = take_byte(w.rx_byte);
                FN_TX_START: begin
                    store    = {w.tx_word0, w.tx_word1, w.tx_word2, w.tx_word3};
                    tx_phase = TX_B1;
                end
                FN_TX_DONE: begin
                    if (tx_phase >= TX_B9)
                        tx_phase = TX_IDLE;
                    else if (tx_phase >= TX_B1)
                        tx_phase++;
                end
                default: begin
                    next = {1'b0, silence} + (TimerW+1)'(1);
                    if (next >= {1'b0, lost_limit}) begin
                        lost    = 1'b1;
                        silence = '0;
                    end else begin
                        silence = next[TimerW-1:0];
                    end
                end
            endcase
            want.tx_char    = char_on_line();
            want.tx_valid   = (tx_phase != TX_IDLE);
            want.tx_idle    = (tx_phase == TX_IDLE);
            want.frame_done = done;
            want.rx_word0   = store.w0;
            want.rx_word1   = store.w1;
            want.rx_word2   = store.w2;
            want.rx_word3   = store.w3;
            want.comms_lost = lost;
            due_words.push_back(want);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                $error("result word with nothing expected: 0x%0h", got);
                errors++;
                return;
            end
            want = due_words.pop_front();
            check_field("tx_char", 16'(want.tx_char), 16'(got.tx_char));
            check_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
            check_field("tx_idle", 16'(want.tx_idle), 16'(got.tx_idle));
            check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
            check_field("rx_word0", 16'(want.rx_word0), 16'(got.rx_word0));
            check_field("rx_word1", want.rx_word1, got.rx_word1);
            check_field("rx_word2", want.rx_word2, got.rx_word2);
            check_field("rx_word3", want.rx_word3, got.rx_word3);
            check_field("comms_lost", 16'(want.comms_lost), 16'(got.comms_lost));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_in_word          in_data = '0;
    logic              out_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [TimerW-1:0] cfg_data = '0;
    logic              in_ready;
    logic              out_valid;
    t_out_word         out_data;
    logic              cfg_ready;

    frame_codec_mirror book = new();

    // Traffic shaping: calm phases run without gaps on either side; a bump of
    // hold_requests makes the result side refuse words for a long stretch.
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    int hold_requests = 0;
    int words_sent = 0;

    seven_bit_frame_codec dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run (every word waiting out the
    // longest gap and the longest stall).
    initial begin
        #(10_000_000);
        $display("seven_bit_frame_codec test failed");
        $finish;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int idle_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Random field values with the extremes weighted in.
    function automatic logic [6:0] pick7();
        case ($urandom_range(0, 5))
            0: return 7'h00;
            1: return 7'h7F;
            default: return 7'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // Fill every field at random so that unused fields toggle too.
    function automatic t_in_word noise_word();
        t_in_word w;
        w.func     = 2'($urandom);
        w.rx_byte  = 8'($urandom);
        w.tx_word0 = 15'($urandom);
        w.tx_word1 = 16'($urandom);
        w.tx_word2 = 16'($urandom);
        w.tx_word3 = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_word rx_word(logic [7:0] c);
        t_in_word w;
        w         = noise_word();
        w.func    = FN_RX_BYTE;
        w.rx_byte = c;
        return w;
    endfunction

    function automatic t_in_word ctl_word(logic [1:0] f);
        t_in_word w;
        w      = noise_word();
        w.func = f;
        return w;
    endfunction

    function automatic t_in_word tx_start_word(logic [14:0] a, logic [15:0] b,
                                               logic [15:0] c, logic [15:0] d);
        t_in_word w;
        w          = noise_word();
        w.func     = FN_TX_START;
        w.tx_word0 = a;
        w.tx_word1 = b;
        w.tx_word2 = c;
        w.tx_word3 = d;
        return w;
    endfunction

    // Offer one word and hold it until the codec takes it. Called at a rising
    // edge; valid stays high across back-to-back words.
    task automatic push_word(t_in_word w);
        int gap;
        gap = idle_len(in_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        book.absorb(w);
        words_sent++;
    endtask

    // Drop valid and wait until every expected result word is back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (book.due_words.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(logic [TimerW-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        book.lost_limit = v;
    endtask

    // Received frame: start byte plus eight data bytes, now and then cut short,
    // with an odd tick or transmit-done slipped in between bytes.
    task automatic send_rx_frame(bit cut);
        int len;
        len = cut ? $urandom_range(1, 8) : 9;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_word(ctl_word($urandom_range(0, 1) ? FN_TICK : FN_TX_DONE));
            push_word(rx_word({i == 0, pick7()}));
        end
    endtask

    // Transmission: load the store, then step it with done words; mostly run
    // to idle, sometimes stop early, sometimes overrun.
    task automatic send_tx_frame();
        int dones;
        push_word(tx_start_word(15'(pick16()), pick16(), pick16(), pick16()));
        dones = ($urandom_range(0, 2) != 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
        for (int i = 0; i < dones; i++) begin
            if ($urandom_range(0, 7) == 0)
                push_word($urandom_range(0, 1) ? ctl_word(FN_TICK) : rx_word({1'b0, pick7()}));
            push_word(ctl_word(FN_TX_DONE));
        end
    endtask

    task automatic run_mix(int count);
        int stop;
        int pick;
        stop = words_sent + count;
        while (words_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_rx_frame($urandom_range(0, 9) == 0);
            else if (pick < 60)
                send_tx_frame();
            else if (pick < 78)
                repeat ($urandom_range(1, 20)) push_word(ctl_word(FN_TICK));
            else
                push_word(noise_word());
        end
    endtask

    // Result side: check each word taken, then pick the next ready level.
    initial begin : result_sink
        int stall_left;
        int served;
        stall_left = 0;
        served     = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
                book.check_word(out_data);
            if (hold_requests != served) begin
                served     = hold_requests;
                stall_left = 120;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!out_calm && $urandom_range(0, 3) == 0)
                    stall_left = idle_len(1'b0);
            end
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset timeout in force.
        push_word(rx_word(8'h00));          // data byte while idle: ignore
        push_word(ctl_word(FN_TX_DONE));    // done while idle: ignore
        push_word(ctl_word(FN_TICK));
        push_word(rx_word(8'hFF));          // all-ones frame, completes on ninth
        repeat (8) push_word(rx_word(8'h7F));
        push_word(rx_word(8'h80));          // partial frame, then restart mid-frame
        push_word(rx_word(8'h55));
        push_word(rx_word(8'hC3));
        push_word(tx_start_word('1, '1, '1, '1));
        push_word(ctl_word(FN_TX_DONE));
        push_word(tx_start_word('0, '0, '0, '0));   // restart while sending
        push_word(rx_word(8'h2A));          // received byte lands in the store being sent
        repeat (10) push_word(ctl_word(FN_TX_DONE)); // ninth byte, then back to idle
        run_mix(220);

        // Timeout of one: every tick flags comms lost.
        set_limit(24'd1);
        run_mix(200);

        set_limit(24'd0);
        run_mix(150);

        // Longest timeout; no gaps, and the result side holds off at the start
        // so the codec fills up and stalls its input.
        set_limit(24'hFFFFFF);
        in_calm  = 1'b1;
        out_calm = 1'b1;
        hold_requests++;
        run_mix(200);

        set_limit(24'd3);
        run_mix(200);
        in_calm  = 1'b0;
        out_calm = 1'b0;

        set_limit(24'd40);
        run_mix(250);

        set_limit(24'($urandom_range(2, 200)));
        run_mix(300);

        wait_drained();
        repeat (8) @(posedge clk);
        if (book.errors == 0)
            $display("seven_bit_frame_codec test passed");
        else
            $display("seven_bit_frame_codec test failed");
        $finish;
    end

endmodule

// File: files.f
hdl/sbfc_pkg.sv
hdl/sbfc_rx_unpack.sv
hdl/sbfc_tx_pack.sv
hdl/seven_bit_frame_codec.sv
tb/seven_bit_frame_codec_tb.sv
